// File: sv/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and codes for the wildcard byte pattern search core
// Register indexes of the configuration port and the pattern settings that
// the front end sees as one bundle.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int PAT_BYTES   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

    typedef struct packed {
        logic [63:0] pattern_high;
        logic [63:0] pattern_low;
        logic [15:0] care_mask;
        logic [4:0]  pattern_length;
    } cfg_t;

endpackage

// File: sv/wbps_queue.sv
// ----------------------------------------------------------------------------
// wbps_queue: two-entry queue between front and back
// Holds match addresses so either side can stall on its own.
// ----------------------------------------------------------------------------
module wbps_queue #(
    parameter int WIDTH = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             nonempty,
    output logic [WIDTH-1:0] head_data
);
    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign nonempty  = (count_reg != 2'd0);
    assign head_data = mem_reg[rd_ptr_reg];

endmodule

// File: sv/wbps_front.sv
// ----------------------------------------------------------------------------
// wbps_front: byte window, fill count and masked compare
// Shifts each accepted byte into the window and flags a full, matching window.
// ----------------------------------------------------------------------------
module wbps_front #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int ADDRESS_BITS      = 48,
    parameter int CW                = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wbps_pkg::cfg_t          cfg,
    input  logic [CW-1:0]           len_eff,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic [ADDRESS_BITS-1:0] byte_address,
    input  logic                    region_start,
    output logic                    push,
    output logic [ADDRESS_BITS-1:0] push_addr
);
    import wbps_pkg::*;

    localparam int IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int NP = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;

    logic [7:0]    win_reg  [MAX_PATTERN_BYTES];
    logic [7:0]    win_next [MAX_PATTERN_BYTES];
    logic [CW-1:0] fill_reg, fill_next;
    logic          hit;
    logic [127:0]  pat_bytes;

    assign pat_bytes = {cfg.pattern_high, cfg.pattern_low};

    // index 0 holds the newest byte; a region start drops all older bytes
    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (k == 0) begin
                win_next[k] = data_byte;
            end else if (region_start) begin
                win_next[k] = 8'h00;
            end else begin
                win_next[k] = win_reg[k-1];
            end
        end
        if (region_start) begin
            fill_next = CW'(1);
        end else if (fill_reg < CW'(MAX_PATTERN_BYTES)) begin
            fill_next = fill_reg + CW'(1);
        end else begin
            fill_next = fill_reg;
        end
    end

    // pattern position j sits at window index len-1-j
    always_comb begin : cmp
        logic          ok;
        logic [CW-1:0] idx_w;
        ok    = 1'b1;
        idx_w = '0;
        for (int j = 0; j < NP; j++) begin
            idx_w = len_eff - CW'(1) - CW'(j);
            if ((CW'(j) < len_eff) && cfg.care_mask[j] &&
                (win_next[idx_w[IW-1:0]] != pat_bytes[8*j +: 8])) begin
                ok = 1'b0;
            end
        end
        hit = ok && (fill_next >= len_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    assign push      = accept && hit;
    assign push_addr = byte_address;

endmodule

// File: sv/wbps_back.sv
// ----------------------------------------------------------------------------
// wbps_back: result stage
// Pops queued hits, rebases the address to the first matched byte, holds it
// in the output register until taken.
// ----------------------------------------------------------------------------
module wbps_back #(
    parameter int ADDRESS_BITS = 48,
    parameter int CW           = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [CW-1:0]           len_eff,
    input  logic                    q_nonempty,
    input  logic [ADDRESS_BITS-1:0] q_addr,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ADDRESS_BITS-1:0] match_address
);
    logic                    valid_reg, valid_next;
    logic [ADDRESS_BITS-1:0] addr_reg;

    assign pop = q_nonempty && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // wraps modulo the address width
    always_ff @(posedge aclk) begin
        if (pop) begin
            addr_reg <= q_addr - ADDRESS_BITS'(len_eff - CW'(1));
        end
    end

    assign m_valid       = valid_reg;
    assign match_address = addr_reg;

endmodule

// File: sv/wildcard_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core: masked byte pattern search over a stream
// Scans one memory byte per beat and reports the start address of each window
// that matches the configured pattern, with unmasked bytes as wildcards.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the queue is not full. A beat is accepted
// on s_tvalid && s_tready; the front end shifts it into a window of the last
// MAX_PATTERN_BYTES bytes and does the masked compare in that same cycle, so
// a matching beat drops its address into a two-entry queue. The back end pops
// the queue, subtracts (pattern_length - 1) to point at the first matched byte
// and holds the result on m_tdata until m_tready. Each accepted byte's result
// passes the queue, then the output register. s_tready drops only while the
// queue is full, which happens only when the output has stalled. Set
// s_tuser on the first byte of each contiguous region, and also after any
// gap left by a failed read: the window is cleared then, and no match spans
// the boundary. Write the pattern registers only while the block is idle; a
// new pattern_length applies at once to the bytes already held. A length of
// zero acts as one, a length above MAX_PATTERN_BYTES as MAX_PATTERN_BYTES,
// and pattern positions beyond sixteen are wildcards.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int ADDRESS_BITS      = 48
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration write port
    input  logic                                     cfg_wr_en,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    // input stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // data_byte [7:0], byte_address [8 +: ADDRESS_BITS], zero fill above
    input  logic [((8+ADDRESS_BITS+7)/8)*8-1:0]      s_tdata,
    // region_start
    input  logic                                     s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // match_address [ADDRESS_BITS-1:0], zero fill above
    output logic [((ADDRESS_BITS+7)/8)*8-1:0]        m_tdata
);
    import wbps_pkg::*;

    localparam int M_TDATA_W = ((ADDRESS_BITS + 7) / 8) * 8;
    localparam int CW        = $clog2(MAX_PATTERN_BYTES + 1);

    cfg_t                    cfg_reg;
    logic [CW-1:0]           len_eff;
    logic                    accept;
    logic                    push;
    logic [ADDRESS_BITS-1:0] push_addr;
    logic                    q_full;
    logic                    q_nonempty;
    logic [ADDRESS_BITS-1:0] q_head;
    logic                    pop;
    logic [ADDRESS_BITS-1:0] match_address;

    // register file: written on any beat of the write enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= '0;
            cfg_reg.pattern_length <= 5'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LOW:    cfg_reg.pattern_low    <= cfg_wdata;
                REG_PATTERN_HIGH:   cfg_reg.pattern_high   <= cfg_wdata;
                REG_CARE_MASK:      cfg_reg.care_mask      <= cfg_wdata[15:0];
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // clamp the length into 1..MAX_PATTERN_BYTES
    always_comb begin
        if (cfg_reg.pattern_length == 5'd0) begin
            len_eff = CW'(1);
        end else if (32'(cfg_reg.pattern_length) > MAX_PATTERN_BYTES) begin
            len_eff = CW'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = CW'(cfg_reg.pattern_length);
        end
    end

    // hold off input only while the queue is full
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wbps_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .ADDRESS_BITS      (ADDRESS_BITS),
        .CW                (CW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .len_eff      (len_eff),
        .accept       (accept),
        .data_byte    (s_tdata[7:0]),
        .byte_address (s_tdata[8 +: ADDRESS_BITS]),
        .region_start (s_tuser),
        .push         (push),
        .push_addr    (push_addr)
    );

    wbps_queue #(
        .WIDTH (ADDRESS_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_addr),
        .pop       (pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head_data (q_head)
    );

    wbps_back #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .CW           (CW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .len_eff       (len_eff),
        .q_nonempty    (q_nonempty),
        .q_addr        (q_head),
        .pop           (pop),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .match_address (match_address)
    );

    // zero-extend the address into the byte-wide bus
    assign m_tdata = M_TDATA_W'(match_address);

endmodule

// File: sv/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker: port-level assertions for the search core
// Watches the stream handshakes and the reset behavior from outside.
// ----------------------------------------------------------------------------
module wbps_checker #(
    parameter int M_TDATA_W = 48
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the output and the queue
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output or queue not empty after reset");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // draining the output frees a queue slot on the next beat
    a_stall_release: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tvalid && m_tready |=> s_tready)
        else $error("input still stalled after result taken");

endmodule

bind wildcard_byte_pattern_search_core wbps_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_wbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
